// ----- sv/ffba_pkg.sv -----
// Package with the shared types, codes and fixed field widths of the first-fit allocator.
`default_nettype none

package ffba_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int REQ_W      = 17;
    localparam int ADDR_W     = 16;
    localparam int STAT_W     = 2;
    localparam int REG_W      = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 24;
    localparam int M_PAD_W    = M_TDATA_W - ADDR_W - STAT_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBUG_MODE   = 1'b1;

    // Operation codes carried in tuser.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NO_SPACE    = 2'd1,
        STATUS_BAD_POINTER = 2'd2,
        STATUS_BAD_SIZE    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_SPLIT,
        ST_FREE_NEXT,
        ST_FREE_PREV,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

// ----- sv/ffba_size_ram.sv -----
// Single-port-write, single-port-read block size memory with a registered read.
`default_nettype none

module ffba_size_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 18,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- sv/first_fit_block_allocator.sv -----
// Top level of the first-fit block allocator: sequencer, region registers and result buffer.
//
//  Channel   Direction  Signals                          Beat contents
//  -------   ---------  -------------------------------  -----------------------------------
//  s_*       in         s_tvalid s_tready s_tdata s_tuser one allocate or free request
//  m_*       out        m_tvalid m_tready m_tdata        status and payload offset
//  cfg_*     in         cfg_wr_en cfg_index cfg_wdata    write of region_bytes or debug_mode
//
// An allocate is accepted, reads one header per block up to the first fit, splits the block
// when a remainder is left and loads the result; a free is accepted, reads one header per
// block up to the block, merges the next block, merges the previous block when it is free,
// and loads the result. Reset and every register write rebuild the region one page at a time
// up to min(max(region, 1), MAX_REGION_BYTES), accepting no beat meanwhile.
// A result waits in the output register while the next request is walked, stalling its result.
`default_nettype none

module first_fit_block_allocator #(
    parameter int MAX_REGION_BYTES = 65536,
    parameter int HEADER_BYTES     = 12,
    parameter int PAD_BYTES        = 64,
    parameter int PAGE_BYTES       = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Request stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ffba_pkg::S_TDATA_W-1:0]     s_tdata,   // request_size, free_address, zeros
    input  logic [0:0]                         s_tuser,   // operation
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ffba_pkg::M_TDATA_W-1:0]     m_tdata,   // status, payload_address, zeros
    // Configuration writes.
    input  logic                               cfg_wr_en,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ffba_pkg::REG_W-1:0]         cfg_wdata
);

    import ffba_pkg::*;

    // Header and pad sizes are kept on whole 32-bit words.
    localparam int HDR         = ((HEADER_BYTES + 3) / 4) * 4;
    localparam int PAD         = ((PAD_BYTES + 3) / 4) * 4;
    localparam int TABLE_DEPTH = (MAX_REGION_BYTES + 3) / 4;
    localparam int OFF_W       = $clog2(MAX_REGION_BYTES + 1);
    localparam int SZ_W        = OFF_W + 1;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CW          = ((OFF_W > REQ_W) ? OFF_W : REQ_W) + 3;

    localparam logic signed [CW-1:0] OVH_STD = CW'(HDR);
    localparam logic signed [CW-1:0] OVH_DBG = CW'(HDR + 2 * PAD);
    localparam logic signed [CW-1:0] PAY_STD = CW'(HDR);
    localparam logic signed [CW-1:0] PAY_DBG = CW'(HDR + PAD);
    localparam logic signed [CW-1:0] PAGE_C  = CW'(PAGE_BYTES);
    localparam logic signed [CW-1:0] MAX_C   = CW'(MAX_REGION_BYTES);
    localparam logic signed [CW-1:0] ONE_C   = CW'(1);

    // Control state.
    state_t                  state_reg, state_next;
    logic                    out_valid_reg, out_valid_next;
    logic [REG_W-1:0]        region_reg, region_next;
    logic                    debug_reg, debug_next;
    logic signed [CW-1:0]    acc_reg, acc_next;
    logic [OFF_W-1:0]        total_reg, total_next;
    logic                    empty_reg, empty_next;

    // Per-request working registers.
    logic                    op_reg, op_next;
    logic [REQ_W:0]          act_reg, act_next;
    logic [ADDR_W-1:0]       faddr_reg, faddr_next;
    logic [OFF_W-1:0]        off_reg, off_next;
    logic [OFF_W-1:0]        prev_reg, prev_next;
    logic signed [SZ_W-1:0]  prev_size_reg, prev_size_next;
    logic                    prev_valid_reg, prev_valid_next;
    logic [OFF_W-1:0]        mag_reg, mag_next;
    logic                    next_ok_reg, next_ok_next;
    status_t                 res_status_reg, res_status_next;
    logic [ADDR_W-1:0]       res_addr_reg, res_addr_next;
    status_t                 out_status_reg, out_status_next;
    logic [ADDR_W-1:0]       out_addr_reg, out_addr_next;

    // Size memory port.
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [SZ_W-1:0]         mem_wdata;
    logic [IDX_W-1:0]        mem_raddr;
    logic [SZ_W-1:0]         mem_rdata;

    // Request fields.
    logic                    in_op;
    logic [REQ_W-1:0]        in_req;
    logic [ADDR_W-1:0]       in_faddr;
    logic [REQ_W:0]          in_act;

    // Arithmetic on one common signed width.
    logic signed [SZ_W-1:0]  rd_size;
    logic signed [CW-1:0]    size_w, mag_s, off_w, total_w, act_w, mag_w, prev_size_w, faddr_w;
    logic signed [CW-1:0]    ovh, pay, next_off, split_off, pay_off, rest, neg_rest;
    logic signed [CW-1:0]    merged, neg_merged, prev_merged;
    logic signed [CW-1:0]    region_w, total_clamp, neg_init;
    logic                    fit, matched, init_done, init_empty;

    ffba_size_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (SZ_W)
    ) u_size_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign in_op    = s_tuser[0];
    assign in_req   = s_tdata[REQ_W-1:0];
    assign in_faddr = s_tdata[REQ_W +: ADDR_W];
    // Requests are rounded up to whole words.
    assign in_act   = ({1'b0, in_req} + (REQ_W + 1)'(3)) & ~(REQ_W + 1)'(3);

    assign rd_size     = mem_rdata;
    assign size_w      = CW'(rd_size);
    assign mag_s       = (size_w < 0) ? -size_w : size_w;
    assign off_w       = CW'(off_reg);
    assign total_w     = CW'(total_reg);
    assign act_w       = CW'(act_reg);
    assign mag_w       = CW'(mag_reg);
    assign prev_size_w = CW'(prev_size_reg);
    assign faddr_w     = CW'(faddr_reg);

    assign ovh = debug_reg ? OVH_DBG : OVH_STD;
    assign pay = debug_reg ? PAY_DBG : PAY_STD;

    // Walk step: header of the following block and the checks on the current one.
    assign next_off  = off_w + ovh + mag_s;
    assign split_off = off_w + ovh + act_w;
    assign pay_off   = off_w + pay;
    assign fit       = size_w <= -act_w;
    assign rest      = mag_s - act_w - ovh;
    assign neg_rest  = -rest;
    assign matched   = pay_off == faddr_w;

    // Free merge: the next block joins when it is inside the region and free.
    assign merged      = mag_w + ((next_ok_reg && (size_w < 0)) ? (ovh - size_w) : '0);
    assign neg_merged  = -merged;
    assign prev_merged = prev_size_w - mag_w - ovh;

    // Region rebuild: the accumulator steps one page a cycle until it covers the request.
    assign region_w    = (region_reg == '0) ? ONE_C : CW'(region_reg);
    assign init_done   = (acc_reg >= region_w) || (acc_reg >= MAX_C);
    assign total_clamp = (acc_reg > MAX_C) ? MAX_C : acc_reg;
    assign init_empty  = total_clamp <= ovh;
    assign neg_init    = ovh - total_clamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
            region_reg    <= REG_W'(4096);
            debug_reg     <= 1'b0;
            acc_reg       <= PAGE_C;
            total_reg     <= '0;
            empty_reg     <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            region_reg    <= region_next;
            debug_reg     <= debug_next;
            acc_reg       <= acc_next;
            total_reg     <= total_next;
            empty_reg     <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        act_reg        <= act_next;
        faddr_reg      <= faddr_next;
        off_reg        <= off_next;
        prev_reg       <= prev_next;
        prev_size_reg  <= prev_size_next;
        prev_valid_reg <= prev_valid_next;
        mag_reg        <= mag_next;
        next_ok_reg    <= next_ok_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

    // The sequencer never overlaps a read and a write of the same header: a request writes
    // only from its last walk step on, and the next walk starts only after the result state.
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        region_next     = region_reg;
        debug_next      = debug_reg;
        acc_next        = acc_reg;
        total_next      = total_reg;
        empty_next      = empty_reg;
        op_next         = op_reg;
        act_next        = act_reg;
        faddr_next      = faddr_reg;
        off_next        = off_reg;
        prev_next       = prev_reg;
        prev_size_next  = prev_size_reg;
        prev_valid_next = prev_valid_reg;
        mag_next        = mag_reg;
        next_ok_next    = next_ok_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_raddr       = '0;
        s_tready        = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                if (init_done)
                begin
                    total_next = total_clamp[OFF_W-1:0];
                    empty_next = init_empty;
                    if (!init_empty)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = neg_init[SZ_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    acc_next = acc_reg + PAGE_C;
                end
            end

            ST_IDLE:
            begin
                s_tready = !cfg_wr_en;
                if (s_tvalid && !cfg_wr_en)
                begin
                    op_next         = in_op;
                    act_next        = in_act;
                    faddr_next      = in_faddr;
                    off_next        = '0;
                    prev_valid_next = 1'b0;
                    res_addr_next   = '0;
                    if (in_op == OP_FREE)
                    begin
                        if (in_faddr == '0)
                        begin
                            res_status_next = STATUS_OK;
                            state_next      = ST_RESULT;
                        end
                        else if (empty_reg)
                        begin
                            res_status_next = STATUS_BAD_POINTER;
                            state_next      = ST_RESULT;
                        end
                        else
                        begin
                            state_next = ST_WALK;
                        end
                    end
                    else
                    begin
                        if (in_req == '0)
                        begin
                            res_status_next = STATUS_BAD_SIZE;
                            state_next      = ST_RESULT;
                        end
                        else if (empty_reg)
                        begin
                            res_status_next = STATUS_NO_SPACE;
                            state_next      = ST_RESULT;
                        end
                        else
                        begin
                            state_next = ST_WALK;
                        end
                    end
                end
            end

            ST_WALK:
            begin
                mem_raddr = next_off[IDX_W+1:2];
                if (op_reg == OP_ALLOC)
                begin
                    if (fit)
                    begin
                        res_status_next = STATUS_OK;
                        res_addr_next   = pay_off[ADDR_W-1:0];
                        mem_we          = 1'b1;
                        if (rest > 0)
                        begin
                            // Carve the tail into a new free block, then size the used one.
                            mem_waddr  = split_off[IDX_W+1:2];
                            mem_wdata  = neg_rest[SZ_W-1:0];
                            state_next = ST_SPLIT;
                        end
                        else
                        begin
                            mem_waddr  = off_reg[IDX_W+1:2];
                            mem_wdata  = mag_s[SZ_W-1:0];
                            state_next = ST_RESULT;
                        end
                    end
                    else if (next_off >= total_w)
                    begin
                        res_status_next = STATUS_NO_SPACE;
                        state_next      = ST_RESULT;
                    end
                    else
                    begin
                        off_next = next_off[OFF_W-1:0];
                    end
                end
                else
                begin
                    if (matched)
                    begin
                        if (size_w <= 0)
                        begin
                            res_status_next = STATUS_BAD_POINTER;
                            state_next      = ST_RESULT;
                        end
                        else
                        begin
                            mag_next     = size_w[OFF_W-1:0];
                            next_ok_next = next_off < total_w;
                            state_next   = ST_FREE_NEXT;
                        end
                    end
                    else
                    begin
                        prev_next       = off_reg;
                        prev_size_next  = rd_size;
                        prev_valid_next = 1'b1;
                        if (next_off >= total_w)
                        begin
                            res_status_next = STATUS_BAD_POINTER;
                            state_next      = ST_RESULT;
                        end
                        else
                        begin
                            off_next = next_off[OFF_W-1:0];
                        end
                    end
                end
            end

            ST_SPLIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = off_reg[IDX_W+1:2];
                mem_wdata  = act_w[SZ_W-1:0];
                state_next = ST_RESULT;
            end

            ST_FREE_NEXT:
            begin
                mem_we          = 1'b1;
                mem_waddr       = off_reg[IDX_W+1:2];
                mem_wdata       = neg_merged[SZ_W-1:0];
                mag_next        = merged[OFF_W-1:0];
                res_status_next = STATUS_OK;
                if (prev_valid_reg && (prev_size_reg < 0))
                begin
                    state_next = ST_FREE_PREV;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end

            ST_FREE_PREV:
            begin
                mem_we     = 1'b1;
                mem_waddr  = prev_reg[IDX_W+1:2];
                mem_wdata  = prev_merged[SZ_W-1:0];
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_INIT;
            end
        endcase

        // A register write restarts the region build.
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_REGION_BYTES: region_next = cfg_wdata;
                CFG_DEBUG_MODE:   debug_next  = cfg_wdata[0];
            endcase
            acc_next   = PAGE_C;
            state_next = ST_INIT;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_addr_reg, out_status_reg};

    // The size memory is written only by the rebuild and the update steps of a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_RESULT) |-> !mem_we)
        else $error("size memory written outside an update step");

    // The walk never leaves the region.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (off_reg < total_reg))
        else $error("walk offset beyond the region");

    // Block headers sit on word boundaries.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (off_reg[1:0] == 2'b00))
        else $error("walk offset not word aligned");

    // A failed request never reports a payload offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != STATUS_OK)) |-> (out_addr_reg == '0))
        else $error("failed request carries a payload offset");

    // A register write blocks requests until the region is rebuilt.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !s_tready)
        else $error("request accepted right after a register write");

endmodule

`default_nettype wire
